FILE: design/mtep_pkg.sv
// Package for the MIDI track event parser: shared constants, status codes
// and the packed input and result types used by every module of the block.
// No dependencies.
package mtep_pkg;

  // Width of the saturating absolute tick counter (32 to 64).
  localparam int unsigned TICK_BITS = 48;
  // Variable-length quantities keep only their low 32 bits.
  localparam int unsigned VLQ_BITS  = 32;
  // Width of the tick carried in a result.
  localparam int unsigned OUT_TICK_BITS = 48;

  // Status and meta codes
  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] META_EOT_TYPE = 8'h2F;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE  = 8'hF7;
  localparam logic [7:0] SYS_MTC_QF    = 8'hF1;
  localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
  localparam logic [3:0] CH_PROG_CHG   = 4'hC;
  localparam logic [3:0] CH_PRESSURE   = 4'hD;
  localparam logic [3:0] SYS_NIBBLE    = 4'hF;

  // One byte of track body
  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  // One decoded event
  typedef struct packed {
    logic [OUT_TICK_BITS-1:0] event_tick;
    logic [7:0]               status_byte;
    logic [6:0]               data_one;
    logic [6:0]               data_two;
    logic [1:0]               event_length;
    logic                     end_of_track;
  } result_t;

  // Parser status towards the top level
  typedef struct packed {
    logic res_valid;
    logic idle;
  } parser_status_t;

endpackage

FILE: design/mtep_in_reg.sv
// Input register stage of the MIDI track event parser.
// Holds one transferred byte until the parser stage can take it.
// Depends on mtep_pkg.
module mtep_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtep_pkg::in_item_t in_item_i,
  input  logic               advance_i,
  output logic               step_o,
  output mtep_pkg::in_item_t item_o
);
  import mtep_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // Free when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign step_o     = valid_q && advance_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: design/mtep_parser.sv
// Byte-wise phase machine of the MIDI track event parser: delta-time
// decoding, saturating tick, message assembly and meta/sysex skipping.
// Depends on mtep_pkg.
module mtep_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  mtep_pkg::in_item_t       item_i,
  output mtep_pkg::result_t        result_o,
  output mtep_pkg::parser_status_t status_o
);
  import mtep_pkg::*;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_META   = 3'd4,
    PH_LEN    = 3'd5,
    PH_SKIP   = 3'd6,
    PH_IDLE   = 3'd7
  } phase_e;

  phase_e               phase_q, phase_d, phase_c;
  logic [VLQ_BITS-1:0]  delta_q, delta_d, delta_c;
  logic [TICK_BITS-1:0] tick_q, tick_d, tick_c;
  logic [7:0]           status_q, status_d, status_c;
  logic [6:0]           first_q, first_d, first_c;
  logic [1:0]           remain_q, remain_d, remain_c;
  logic [VLQ_BITS-1:0]  skip_q, skip_d, skip_c;

  logic [7:0]           b;
  logic [VLQ_BITS-1:0]  delta_shift;
  logic [VLQ_BITS-1:0]  skip_shift;
  logic [VLQ_BITS-1:0]  skip_dec;
  logic [TICK_BITS:0]   tick_sum;
  logic [1:0]           need;
  logic                 res_valid;
  result_t              res;

  assign b = item_i.data_byte;

  // Track start clears everything before the byte is used
  always_comb begin
    if (item_i.track_start) begin
      phase_c  = PH_DELTA;
      delta_c  = '0;
      tick_c   = '0;
      status_c = '0;
      first_c  = '0;
      remain_c = '0;
      skip_c   = '0;
    end else begin
      phase_c  = phase_q;
      delta_c  = delta_q;
      tick_c   = tick_q;
      status_c = status_q;
      first_c  = first_q;
      remain_c = remain_q;
      skip_c   = skip_q;
    end
  end

  // Quantity shift-in, saturating add, skip countdown
  assign delta_shift = {delta_c[VLQ_BITS-8:0], b[6:0]};
  assign skip_shift  = {skip_c[VLQ_BITS-8:0], b[6:0]};
  assign skip_dec    = (skip_c != '0) ? skip_c - VLQ_BITS'(1) : skip_c;
  assign tick_sum    = {1'b0, tick_c} + (TICK_BITS+1)'(delta_shift);

  // Data bytes needed after a status byte
  always_comb begin
    if (b[7:4] != SYS_NIBBLE) begin
      need = (b[7:4] == CH_PROG_CHG || b[7:4] == CH_PRESSURE) ? 2'd1 : 2'd2;
    end else if (b == SYS_MTC_QF || b == SYS_SONG_SEL) begin
      need = 2'd1;
    end else if (b == SYS_SONG_POS) begin
      need = 2'd2;
    end else begin
      need = 2'd0;
    end
  end

  // Phase machine
  always_comb begin
    phase_d   = phase_c;
    delta_d   = delta_c;
    tick_d    = tick_c;
    status_d  = status_c;
    first_d   = first_c;
    remain_d  = remain_c;
    skip_d    = skip_c;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_c)
      PH_DELTA: begin
        delta_d = delta_shift;
        if (!b[7]) begin
          tick_d  = tick_sum[TICK_BITS] ? '1 : tick_sum[TICK_BITS-1:0];
          delta_d = '0;
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          phase_d = PH_DELTA;
        end else if (b == META_STATUS) begin
          phase_d = PH_META;
        end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
          skip_d  = '0;
          phase_d = PH_LEN;
        end else begin
          status_d = b;
          remain_d = need;
          if (need == 2'd0) begin
            phase_d          = PH_DELTA;
            res_valid        = 1'b1;
            res.event_tick   = OUT_TICK_BITS'(tick_c);
            res.status_byte  = b;
            res.event_length = 2'd1;
          end else begin
            phase_d = PH_DATA1;
          end
        end
      end
      PH_DATA1: begin
        first_d = b[6:0];
        if (remain_c == 2'd1) begin
          remain_d         = '0;
          phase_d          = PH_DELTA;
          res_valid        = 1'b1;
          res.event_tick   = OUT_TICK_BITS'(tick_c);
          res.status_byte  = status_c;
          res.data_one     = b[6:0];
          res.event_length = 2'd2;
        end else begin
          remain_d = 2'd1;
          phase_d  = PH_DATA2;
        end
      end
      PH_DATA2: begin
        remain_d         = '0;
        phase_d          = PH_DELTA;
        res_valid        = 1'b1;
        res.event_tick   = OUT_TICK_BITS'(tick_c);
        res.status_byte  = status_c;
        res.data_one     = first_c;
        res.data_two     = b[6:0];
        res.event_length = 2'd3;
      end
      PH_META: begin
        if (b == META_EOT_TYPE) begin
          phase_d          = PH_IDLE;
          res_valid        = 1'b1;
          res.event_tick   = OUT_TICK_BITS'(tick_c);
          res.end_of_track = 1'b1;
        end else begin
          skip_d  = '0;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        skip_d = skip_shift;
        if (!b[7]) begin
          phase_d = (skip_shift == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PH_DELTA;
        end
      end
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_DELTA;
      end
    endcase
  end

  assign result_o           = res;
  assign status_o.res_valid = step_i && res_valid;
  assign status_o.idle      = (phase_q == PH_IDLE);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA;
      delta_q  <= '0;
      tick_q   <= '0;
      status_q <= '0;
      first_q  <= '0;
      remain_q <= '0;
      skip_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      delta_q  <= delta_d;
      tick_q   <= tick_d;
      status_q <= status_d;
      first_q  <= first_d;
      remain_q <= remain_d;
      skip_q   <= skip_d;
    end
  end

endmodule

FILE: design/mtep_out_reg.sv
// Result register of the MIDI track event parser.
// Holds one decoded event until the downstream side takes it.
// Depends on mtep_pkg.
module mtep_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mtep_pkg::result_t result_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtep_pkg::result_t out_item_o
);
  import mtep_pkg::*;

  logic    valid_q, valid_d;
  result_t item_q;

  // Parser may move on when the register is empty or drains now
  assign advance_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      item_q <= result_i;
    end
  end

endmodule

FILE: design/midi_track_event_parser_core.sv
// MIDI track event parser, top level. Depends on mtep_pkg, mtep_in_reg,
// mtep_parser and mtep_out_reg.
// Throughput: one byte per cycle unless the full result register stalls.
// The phase machine steps once per byte and registers each result.
// Reset (rst_ni, asynchronous, active low): empty stages, phase expects a
// delta time, tick and held fields cleared.
module midi_track_event_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtep_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mtep_pkg::result_t  out_item_o
);
  import mtep_pkg::*;

  logic           advance;
  logic           step;
  in_item_t       item;
  result_t        result;
  parser_status_t pstat;

  // Input register
  mtep_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .step_o     (step),
    .item_o     (item)
  );

  // Phase machine
  mtep_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .result_o (result),
    .status_o (pstat)
  );

  // Result register
  mtep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (pstat.res_valid),
    .result_i    (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Input side stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  // A result is produced only for a byte that actually steps the parser
  a_result_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pstat.res_valid |-> step)
    else $error("result without a parser step");

  // End of track leaves the parser idle
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pstat.res_valid && result.end_of_track) |=> pstat.idle)
    else $error("parser not idle after end of track");

  // A loaded result appears on the output in the next cycle
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pstat.res_valid |=> (out_valid_o && out_item_o == $past(result)))
    else $error("result not registered");

endmodule
